// ===== rtl/ttq_pkg.sv =====
`default_nettype none

package ttq_pkg;

    localparam int HANDS_DEF = 2;

    // Register map: register i at byte address 4*i
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_PRESS_LEVEL   = 3'd0,
        REG_RELEASE_LEVEL = 3'd1,
        REG_MIN_HOLD_MS   = 3'd2,
        REG_TAP_GAP_MS    = 3'd3,
        REG_PLAY_GAP_MS   = 3'd4
    } ttq_reg_idx_t;

    localparam logic [7:0]  PRESS_LEVEL_RST   = 8'd184;
    localparam logic [7:0]  RELEASE_LEVEL_RST = 8'd56;
    localparam logic [15:0] MIN_HOLD_MS_RST   = 16'd25;
    localparam logic [15:0] TAP_GAP_MS_RST    = 16'd550;
    localparam logic [15:0] PLAY_GAP_MS_RST   = 16'd300;

    typedef struct packed {
        logic        hand;
        logic        analog_active;
        logic [7:0]  analog_level;
        logic        click_active;
        logic        click_level;
        logic [31:0] now_ms;
        logic        mark_timeline;
        logic        mark_ui;
    } ttq_in_t;

    typedef struct packed {
        logic is_pressed;
        logic press_edge;
        logic release_edge;
        logic release_consumed;
        logic play_toggle;
    } ttq_out_t;

    typedef struct packed {
        logic [7:0]  press_level;
        logic [7:0]  release_level;
        logic [15:0] min_hold_ms;
        logic [15:0] tap_gap_ms;
        logic [15:0] play_gap_ms;
    } ttq_cfg_t;

    typedef struct packed {
        logic        pressed;
        logic        tl_mark;
        logic        ui_mark;
        logic [31:0] press_time;
        logic [31:0] last_tap_time;
        logic        last_tap_valid;
    } ttq_hand_t;

    typedef struct packed {
        logic [31:0] last_play_time;
        logic        last_play_valid;
    } ttq_play_t;

endpackage

`default_nettype wire

// ===== rtl/trigger_tap_qualifier_unit.sv =====
`default_nettype none

// Trigger tap qualifier.
// Input channel s_valid/s_ready/s_data carries one trigger sample per transaction:
// hand, analog and click levels with their active flags, a millisecond timestamp
// and the consumed marks. Result channel m_valid/m_ready/m_data returns exactly one
// transaction per sample: pressed state, press/release edges, consumed release and
// the play/pause tap.
// Thresholds and gaps sit in an APB register file (press, release, min hold, tap
// gap, play gap at byte addresses 0, 4, 8, 12, 16); write only while idle.
// Path: input register, evaluation, result register. Throughput: one sample per cycle
// while the receiver takes results, set by the input register, one evaluation stage
// and the result register; per-hand state is read and written back in that stage.
// Reset (aresetn low, synchronous): registers return to their defaults, all hands
// are released with no marks and no tap history, and both channels go empty.
// A stalled receiver holds the result register; the input register still takes
// one more sample, then s_ready drops until the result is taken.
module trigger_tap_qualifier_unit #(
    parameter int HANDS = ttq_pkg::HANDS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ttq_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [ttq_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [ttq_pkg::CFG_DATA_W-1:0] prdata,
    output logic                               pready,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire ttq_pkg::ttq_in_t              s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output ttq_pkg::ttq_out_t                  m_data
);

    ttq_pkg::ttq_cfg_t  cfg;

    // input stage
    ttq_pkg::ttq_in_t   in_reg;
    logic               in_vld_reg;

    // result stage
    ttq_pkg::ttq_out_t  m_data_reg;
    logic               m_valid_reg;

    // per-hand state: control bits reset, timestamps do not
    logic               pressed_reg    [HANDS];
    logic               tl_mark_reg    [HANDS];
    logic               ui_mark_reg    [HANDS];
    logic               tap_valid_reg  [HANDS];
    logic [31:0]        press_time_reg [HANDS];
    logic [31:0]        tap_time_reg   [HANDS];

    ttq_pkg::ttq_play_t play_reg;
    ttq_pkg::ttq_play_t play_next;

    logic [HANDS-1:0]   hit;
    logic               hit_any;
    ttq_pkg::ttq_hand_t hand_cur;
    ttq_pkg::ttq_hand_t hand_next;
    ttq_pkg::ttq_out_t  res;
    logic               advance;

    ttq_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Evaluate the held sample whenever the result register is free or draining.
    assign advance = in_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Pick the addressed hand; a hand index of HANDS or more hits nothing.
    always_comb begin
        hand_cur = '0;
        for (int h = 0; h < HANDS; h++) begin
            hit[h] = ({31'd0, in_reg.hand} == 32'(h));
            if (hit[h]) begin
                hand_cur.pressed        = pressed_reg[h];
                hand_cur.tl_mark        = tl_mark_reg[h];
                hand_cur.ui_mark        = ui_mark_reg[h];
                hand_cur.press_time     = press_time_reg[h];
                hand_cur.last_tap_time  = tap_time_reg[h];
                hand_cur.last_tap_valid = tap_valid_reg[h];
            end
        end
        hit_any = |hit;
    end

    ttq_eval u_eval (
        .item     (in_reg),
        .hit      (hit_any),
        .cfg      (cfg),
        .hand_cur (hand_cur),
        .play_cur (play_reg),
        .res      (res),
        .hand_nx  (hand_next),
        .play_nx  (play_next)
    );

    // Write back the addressed hand on the same edge that loads the result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int h = 0; h < HANDS; h++) begin
                pressed_reg[h]   <= 1'b0;
                tl_mark_reg[h]   <= 1'b0;
                ui_mark_reg[h]   <= 1'b0;
                tap_valid_reg[h] <= 1'b0;
            end
        end else if (advance) begin
            for (int h = 0; h < HANDS; h++) begin
                if (hit[h]) begin
                    pressed_reg[h]   <= hand_next.pressed;
                    tl_mark_reg[h]   <= hand_next.tl_mark;
                    ui_mark_reg[h]   <= hand_next.ui_mark;
                    tap_valid_reg[h] <= hand_next.last_tap_valid;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int h = 0; h < HANDS; h++) begin
                if (hit[h]) begin
                    press_time_reg[h] <= hand_next.press_time;
                    tap_time_reg[h]   <= hand_next.last_tap_time;
                end
            end
        end
    end

    // Global play/pause debounce: the time only matters once the valid bit is set.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            play_reg <= '0;
        end else if (advance) begin
            play_reg <= play_next;
        end
    end

    // Result register: hold while the receiver stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= res;
        end
    end

`ifndef ASSERT_OFF
    a_edges_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg.press_edge && m_data_reg.release_edge))
        else $error("press and release edge in one result");

    a_consumed_needs_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.release_consumed) |-> m_data_reg.release_edge)
        else $error("consumed flag without release edge");

    a_play_needs_clean_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.play_toggle)
            |-> (m_data_reg.release_edge && !m_data_reg.release_consumed))
        else $error("play/pause without unconsumed release");

    a_press_shows_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.press_edge) |-> m_data_reg.is_pressed)
        else $error("press edge but hand not pressed");

    a_play_sets_debounce: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res.play_toggle) |=> (play_reg.last_play_valid && m_valid_reg))
        else $error("play/pause did not arm global debounce");
`endif

endmodule

`default_nettype wire

// ===== rtl/ttq_cfg_regs.sv =====
`default_nettype none

module ttq_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ttq_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [ttq_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [ttq_pkg::CFG_DATA_W-1:0] prdata,
    output logic                               pready,
    output ttq_pkg::ttq_cfg_t                  cfg
);

    ttq_pkg::ttq_cfg_t    cfg_reg;
    ttq_pkg::ttq_reg_idx_t idx;
    logic                 wr_en;

    assign idx    = ttq_pkg::ttq_reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.press_level   <= ttq_pkg::PRESS_LEVEL_RST;
            cfg_reg.release_level <= ttq_pkg::RELEASE_LEVEL_RST;
            cfg_reg.min_hold_ms   <= ttq_pkg::MIN_HOLD_MS_RST;
            cfg_reg.tap_gap_ms    <= ttq_pkg::TAP_GAP_MS_RST;
            cfg_reg.play_gap_ms   <= ttq_pkg::PLAY_GAP_MS_RST;
        end else if (wr_en) begin
            unique case (idx)
                ttq_pkg::REG_PRESS_LEVEL:   cfg_reg.press_level   <= pwdata[7:0];
                ttq_pkg::REG_RELEASE_LEVEL: cfg_reg.release_level <= pwdata[7:0];
                ttq_pkg::REG_MIN_HOLD_MS:   cfg_reg.min_hold_ms   <= pwdata[15:0];
                ttq_pkg::REG_TAP_GAP_MS:    cfg_reg.tap_gap_ms    <= pwdata[15:0];
                ttq_pkg::REG_PLAY_GAP_MS:   cfg_reg.play_gap_ms   <= pwdata[15:0];
                default: ;  // drop writes beyond the map
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            ttq_pkg::REG_PRESS_LEVEL:   prdata = {24'd0, cfg_reg.press_level};
            ttq_pkg::REG_RELEASE_LEVEL: prdata = {24'd0, cfg_reg.release_level};
            ttq_pkg::REG_MIN_HOLD_MS:   prdata = {16'd0, cfg_reg.min_hold_ms};
            ttq_pkg::REG_TAP_GAP_MS:    prdata = {16'd0, cfg_reg.tap_gap_ms};
            ttq_pkg::REG_PLAY_GAP_MS:   prdata = {16'd0, cfg_reg.play_gap_ms};
            default:                    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ttq_eval.sv =====
`default_nettype none

module ttq_eval (
    input  wire ttq_pkg::ttq_in_t   item,
    input  wire logic               hit,
    input  wire ttq_pkg::ttq_cfg_t  cfg,
    input  wire ttq_pkg::ttq_hand_t hand_cur,
    input  wire ttq_pkg::ttq_play_t play_cur,
    output ttq_pkg::ttq_out_t       res,
    output ttq_pkg::ttq_hand_t      hand_nx,
    output ttq_pkg::ttq_play_t      play_nx
);

    logic        tl_mark;
    logic        ui_mark;
    logic        inactive;
    logic        analog_down;
    logic        down;
    logic        pe;
    logic        re;
    logic        rc;
    logic [31:0] held;
    logic [31:0] tap_gap;
    logic [31:0] play_gap;
    logic        tap;
    logic        play_block;
    logic        pp;

    always_comb begin
        // marks only stick while the hand was already pressed
        tl_mark  = hand_cur.tl_mark | (hand_cur.pressed & item.mark_timeline);
        ui_mark  = hand_cur.ui_mark | (hand_cur.pressed & item.mark_ui);
        inactive = !item.analog_active && !item.click_active;

        analog_down = hand_cur.pressed ? (item.analog_level > cfg.release_level)
                                       : (item.analog_level >= cfg.press_level);
        down = (item.analog_active & analog_down) | (item.click_active & item.click_level);

        pe = hit && !inactive && !hand_cur.pressed && down;
        re = hit && !inactive && hand_cur.pressed && !down;
        rc = re && (tl_mark || ui_mark);

        held     = item.now_ms - hand_cur.press_time;
        tap_gap  = item.now_ms - hand_cur.last_tap_time;
        play_gap = item.now_ms - play_cur.last_play_time;

        tap = re && !rc && (held >= {16'd0, cfg.min_hold_ms})
              && (!hand_cur.last_tap_valid || (tap_gap >= {16'd0, cfg.tap_gap_ms}));
        play_block = play_cur.last_play_valid && (play_gap < {16'd0, cfg.play_gap_ms});
        pp = tap && !play_block;

        hand_nx = hand_cur;
        if (inactive) begin
            hand_nx.pressed = 1'b0;
            hand_nx.tl_mark = 1'b0;
            hand_nx.ui_mark = 1'b0;
        end else if (pe) begin
            hand_nx.pressed    = 1'b1;
            hand_nx.tl_mark    = 1'b0;
            hand_nx.ui_mark    = 1'b0;
            hand_nx.press_time = item.now_ms;
        end else if (re) begin
            hand_nx.pressed = 1'b0;
            hand_nx.tl_mark = 1'b0;
            hand_nx.ui_mark = 1'b0;
            if (tap) begin
                hand_nx.last_tap_time  = item.now_ms;
                hand_nx.last_tap_valid = 1'b1;
            end
        end else begin
            hand_nx.tl_mark = tl_mark;
            hand_nx.ui_mark = ui_mark;
        end

        play_nx = play_cur;
        if (pp) begin
            play_nx.last_play_time  = item.now_ms;
            play_nx.last_play_valid = 1'b1;
        end

        res.is_pressed       = hit && !inactive && (pe || (hand_cur.pressed && !re));
        res.press_edge       = pe;
        res.release_edge     = re;
        res.release_consumed = rc;
        res.play_toggle      = pp;
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;

    // Trigger sample stream in, tap verdicts out.
    // Hold the samples in a queue filled per register setting, drive them through
    // the input channel with random gaps, predict each verdict at acceptance and
    // compare at the result channel with random stalls.

    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int DRAIN_CYCLES     = 4;
    localparam int MAX_WAIT         = 11;
    localparam int SHOWN_MISMATCHES = 10;

    typedef enum logic [1:0] {
        SRC_ANALOG,
        SRC_CLICK,
        SRC_BOTH,
        SRC_NONE
    } trig_source_t;

    logic                           aclk    = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [ttq_pkg::CFG_ADDR_W-1:0] paddr   = '0;
    logic [ttq_pkg::CFG_DATA_W-1:0] pwdata  = '0;
    logic [ttq_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    ttq_pkg::ttq_in_t               s_data  = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    ttq_pkg::ttq_out_t              m_data;

    trigger_tap_qualifier_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Shadow copy of the register file, updated as each write lands.
    logic [7:0]  thr_press   = ttq_pkg::PRESS_LEVEL_RST;
    logic [7:0]  thr_release = ttq_pkg::RELEASE_LEVEL_RST;
    logic [15:0] hold_min    = ttq_pkg::MIN_HOLD_MS_RST;
    logic [15:0] tap_gap     = ttq_pkg::TAP_GAP_MS_RST;
    logic [15:0] play_gap    = ttq_pkg::PLAY_GAP_MS_RST;

    // Shadow per-hand trigger state and the shared play/pause history.
    logic [1:0]  hand_down   = '0;
    logic [1:0]  tl_consumed = '0;
    logic [1:0]  ui_consumed = '0;
    logic [1:0]  tap_seen    = '0;
    logic [31:0] press_stamp [2];
    logic [31:0] tap_stamp   [2];
    logic [31:0] play_stamp  = '0;
    logic        play_seen   = 1'b0;

    ttq_pkg::ttq_in_t  samples_pending [$];
    ttq_pkg::ttq_out_t verdicts_due    [$];
    ttq_pkg::ttq_out_t due_verdict;

    // Sample generator state: one gesture in flight per hand.
    logic [1:0]   want_down  = '0;
    int           steps_left [2];
    trig_source_t source_mode [2];
    logic [31:0]  clock_ms = 32'd5000;
    int unsigned  stride   = 120;

    int  gap_left       = 0;
    int  stall_left     = 0;
    bit  sender_gappy   = 1'b1;
    bit  receiver_gappy = 1'b1;
    int  idle_cycles    = 0;
    int  errors         = 0;
    int  samples_taken  = 0;
    int  verdicts_seen  = 0;
    int  taps_emitted   = 0;
    int  consumed_seen  = 0;
    int  settings_used  = 1;
    logic loaded        = 1'b0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Work out the verdict for one sample and advance the shadow state.
    function automatic ttq_pkg::ttq_out_t qualify_sample(input ttq_pkg::ttq_in_t smp);
        ttq_pkg::ttq_out_t res;
        logic        down;
        int          h;
        logic [31:0] held;
        logic [31:0] since_tap;
        logic [31:0] since_play;
        res  = '0;
        down = 1'b0;
        h    = int'(smp.hand);
        // Marks only stick to a press that is already under way.
        if (hand_down[h]) begin
            if (smp.mark_timeline) tl_consumed[h] = 1'b1;
            if (smp.mark_ui) ui_consumed[h] = 1'b1;
        end
        // No live source: drop the hand silently.
        if (!smp.analog_active && !smp.click_active) begin
            hand_down[h]   = 1'b0;
            tl_consumed[h] = 1'b0;
            ui_consumed[h] = 1'b0;
            return res;
        end
        if (smp.analog_active)
            down = hand_down[h] ? (smp.analog_level > thr_release)
                                : (smp.analog_level >= thr_press);
        if (smp.click_active)
            down = down | smp.click_level;
        if (!hand_down[h] && down) begin
            hand_down[h]   = 1'b1;
            tl_consumed[h] = 1'b0;
            ui_consumed[h] = 1'b0;
            press_stamp[h] = smp.now_ms;
            res.press_edge = 1'b1;
        end else if (hand_down[h] && !down) begin
            res.release_consumed = tl_consumed[h] | ui_consumed[h];
            held       = smp.now_ms - press_stamp[h];
            since_tap  = smp.now_ms - tap_stamp[h];
            since_play = smp.now_ms - play_stamp;
            if (!res.release_consumed && held >= {16'd0, hold_min} &&
                (!tap_seen[h] || since_tap >= {16'd0, tap_gap})) begin
                // The global gap may still swallow the event; the hand's tap time moves anyway.
                if (!play_seen || since_play >= {16'd0, play_gap}) begin
                    res.play_toggle = 1'b1;
                    play_stamp      = smp.now_ms;
                    play_seen       = 1'b1;
                end
                tap_stamp[h] = smp.now_ms;
                tap_seen[h]  = 1'b1;
            end
            hand_down[h]     = 1'b0;
            tl_consumed[h]   = 1'b0;
            ui_consumed[h]   = 1'b0;
            res.release_edge = 1'b1;
        end
        res.is_pressed = hand_down[h];
        return res;
    endfunction

    function automatic void note_failure(input string msg);
        errors++;
        if (errors <= SHOWN_MISMATCHES)
            $display("%s", msg);
    endfunction

    function automatic void queue_sample(input int hand, input int a_act,
                                         input logic [7:0] lvl, input int c_act,
                                         input int c_lvl, input logic [31:0] now,
                                         input int m_tl, input int m_ui);
        ttq_pkg::ttq_in_t smp;
        smp.hand          = 1'(hand);
        smp.analog_active = 1'(a_act);
        smp.analog_level  = lvl;
        smp.click_active  = 1'(c_act);
        smp.click_level   = 1'(c_lvl);
        smp.now_ms        = now;
        smp.mark_timeline = 1'(m_tl);
        smp.mark_ui       = 1'(m_ui);
        samples_pending.insert(samples_pending.size(), smp);
    endfunction

    // Draw a level from [lo, hi]; fall back to the full range when empty.
    function automatic logic [7:0] pick_level(input int lo, input int hi);
        if (lo > hi)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(hi, lo));
    endfunction

    // Mostly well-formed press/hold/release gestures, interleaved across hands,
    // with a thin layer of random noise samples on top.
    task automatic queue_gestures(input int count);
        ttq_pkg::ttq_in_t smp;
        logic [63:0] noise;
        int          h;
        int          i;
        int          roll;
        for (i = 0; i < count; i++) begin
            h = $urandom_range(0, 1);
            if (steps_left[h] == 0) begin
                want_down[h]  = ~want_down[h];
                steps_left[h] = $urandom_range(1, 6);
                if (want_down[h]) begin
                    roll = $urandom_range(0, 19);
                    source_mode[h] = roll < 11 ? SRC_ANALOG :
                                     roll < 14 ? SRC_CLICK  :
                                     roll < 19 ? SRC_BOTH   : SRC_NONE;
                end
            end
            steps_left[h]--;
            // Advance time; now and then jump far ahead.
            if ($urandom_range(0, 63) == 0)
                clock_ms += $urandom_range(0, 4 * stride);
            else
                clock_ms += $urandom_range(0, stride);
            if ($urandom_range(0, 31) == 0) begin
                noise = {$urandom, $urandom};
                smp   = noise[$bits(ttq_pkg::ttq_in_t)-1:0];
            end else begin
                smp.hand   = h[0];
                smp.now_ms = clock_ms;
                smp.analog_active = source_mode[h] inside {SRC_ANALOG, SRC_BOTH};
                smp.click_active  = source_mode[h] inside {SRC_CLICK, SRC_BOTH};
                if ($urandom_range(0, 31) == 0) begin
                    smp.analog_active = 1'b0;
                    smp.click_active  = 1'b0;
                end
                roll = $urandom_range(0, 9);
                if (roll >= 7)
                    smp.analog_level = pick_level(int'(thr_release) + 1, int'(thr_press) - 1);
                else if (want_down[h])
                    smp.analog_level = pick_level(int'(thr_press), 255);
                else
                    smp.analog_level = pick_level(0, int'(thr_release));
                smp.click_level   = want_down[h] ^ ($urandom_range(0, 9) == 0);
                smp.mark_timeline = ($urandom_range(0, 11) == 0);
                smp.mark_ui       = ($urandom_range(0, 11) == 0);
            end
            samples_pending.insert(samples_pending.size(), smp);
        end
    endtask

    // APB write: setup cycle, access cycle, then drop the select.
    task automatic write_reg(input ttq_pkg::ttq_reg_idx_t idx, input logic [15:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ttq_pkg::REG_PRESS_LEVEL:   thr_press   = val[7:0];
            ttq_pkg::REG_RELEASE_LEVEL: thr_release = val[7:0];
            ttq_pkg::REG_MIN_HOLD_MS:   hold_min    = val;
            ttq_pkg::REG_TAP_GAP_MS:    tap_gap     = val;
            ttq_pkg::REG_PLAY_GAP_MS:   play_gap    = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [7:0] p, input logic [7:0] r,
                                  input logic [15:0] mh, input logic [15:0] tg,
                                  input logic [15:0] pg);
        write_reg(ttq_pkg::REG_PRESS_LEVEL,   {8'd0, p});
        write_reg(ttq_pkg::REG_RELEASE_LEVEL, {8'd0, r});
        write_reg(ttq_pkg::REG_MIN_HOLD_MS,   mh);
        write_reg(ttq_pkg::REG_TAP_GAP_MS,    tg);
        write_reg(ttq_pkg::REG_PLAY_GAP_MS,   pg);
        settings_used++;
    endtask

    // Hold until the sender is empty and every verdict is back, then let the
    // pipeline settle.
    task automatic wait_drained();
        while (samples_pending.size() != 0 || loaded || s_valid ||
               verdicts_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Driver: present one sample at a time, predict it when it is accepted,
    // then idle for a drawn number of cycles before loading the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            loaded = s_valid;
            if (s_valid && s_ready) begin
                verdicts_due.insert(verdicts_due.size(), qualify_sample(s_data));
                samples_taken++;
                loaded   = 1'b0;
                gap_left = sender_gappy ? $urandom_range(0, MAX_WAIT) : 0;
                if ($urandom_range(0, 49) == 0) sender_gappy = ~sender_gappy;
            end
            if (!loaded && gap_left > 0) begin
                gap_left--;
            end else if (!loaded && samples_pending.size() != 0) begin
                s_data <= samples_pending.pop_front();
                loaded = 1'b1;
            end
            s_valid <= loaded;
        end
    end

    // Monitor: check each verdict against the oldest prediction, then stall
    // the result channel for a drawn number of cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                verdicts_seen++;
                if (verdicts_due.size() == 0) begin
                    note_failure($sformatf("verdict %0d with no sample waiting: %b",
                                           verdicts_seen, m_data));
                end else begin
                    due_verdict = verdicts_due.pop_front();
                    if (m_data !== due_verdict)
                        note_failure($sformatf({"verdict %0d mismatch ",
                            "(pressed press_edge release_edge consumed play): ",
                            "expected %b %b %b %b %b, got %b %b %b %b %b"},
                            verdicts_seen,
                            due_verdict.is_pressed, due_verdict.press_edge,
                            due_verdict.release_edge, due_verdict.release_consumed,
                            due_verdict.play_toggle,
                            m_data.is_pressed, m_data.press_edge, m_data.release_edge,
                            m_data.release_consumed, m_data.play_toggle));
                    if (due_verdict.play_toggle) taps_emitted++;
                    if (due_verdict.release_consumed) consumed_seen++;
                end
                stall_left = receiver_gappy ? $urandom_range(0, MAX_WAIT) : 0;
                if ($urandom_range(0, 49) == 0) receiver_gappy = ~receiver_gappy;
            end
            m_ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // Count cycles with no transaction on either channel and no register access.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("timeout: no transaction for %0d cycles, %0d verdicts outstanding",
                 WATCHDOG_LIMIT, verdicts_due.size());
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        int          k;
        logic [7:0]  p;
        logic [7:0]  r;
        logic [15:0] mh;
        logic [15:0] tg;
        logic [15:0] pg;
        for (k = 0; k < 2; k++) begin
            press_stamp[k] = '0;
            tap_stamp[k]   = '0;
            steps_left[k]  = 0;
            source_mode[k] = SRC_ANALOG;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed pass at reset settings.
        // Both sources inactive: everything zero, marks irrelevant.
        queue_sample(0, 0, 8'd255, 0, 1, 32'd1000, 1, 1);
        // Marks while released are dropped; level below threshold.
        queue_sample(0, 1, 8'd100, 0, 0, 32'd1005, 1, 1);
        // Press exactly at threshold, hold in the hysteresis band, release at
        // the release level one ms short of the minimum hold.
        queue_sample(0, 1, 8'd184, 0, 0, 32'd1010, 0, 0);
        queue_sample(0, 1, 8'd57,  0, 0, 32'd1020, 0, 0);
        queue_sample(0, 1, 8'd56,  0, 0, 32'd1034, 0, 0);
        // Clean tap held exactly the minimum: first play/pause.
        queue_sample(0, 1, 8'd255, 0, 0, 32'd2000, 0, 0);
        queue_sample(0, 1, 8'd0,   0, 0, 32'd2025, 0, 0);
        // Click-only tap on the other hand, swallowed by the global gap.
        queue_sample(1, 0, 8'd0, 1, 1, 32'd2100, 0, 0);
        queue_sample(1, 0, 8'd0, 1, 0, 32'd2200, 0, 0);
        // Same hand again inside its own tap gap.
        queue_sample(1, 0, 8'd255, 1, 1, 32'd2300, 0, 0);
        queue_sample(1, 0, 8'd255, 1, 0, 32'd2600, 0, 0);
        // Timeline mark during a press consumes the release.
        queue_sample(0, 1, 8'd200, 0, 0, 32'd2700, 0, 0);
        queue_sample(0, 1, 8'd200, 0, 0, 32'd2710, 1, 0);
        queue_sample(0, 1, 8'd0,   0, 0, 32'd2800, 0, 0);
        // Interface mark, released from below the release level.
        queue_sample(0, 1, 8'd255, 0, 0, 32'd3000, 0, 0);
        queue_sample(0, 1, 8'd255, 0, 0, 32'd3050, 0, 1);
        queue_sample(0, 1, 8'd30,  0, 0, 32'd3100, 0, 0);
        // Sources drop out mid-press: state clears with no release edge.
        queue_sample(0, 1, 8'd255, 0, 0, 32'd3200, 0, 0);
        queue_sample(0, 0, 8'd0,   0, 0, 32'd3250, 0, 0);
        queue_sample(0, 1, 8'd0,   0, 0, 32'd3300, 0, 0);
        // Both sources active: click holds, then analog holds, then release.
        queue_sample(1, 1, 8'd0,   1, 1, 32'd4000, 0, 0);
        queue_sample(1, 1, 8'd255, 1, 0, 32'd4050, 0, 0);
        queue_sample(1, 1, 8'd40,  1, 0, 32'd4100, 0, 0);
        // Press just before the time counter wraps, release just after.
        queue_sample(1, 1, 8'd255, 0, 0, 32'hFFFF_FFF0, 0, 0);
        queue_sample(1, 1, 8'd0,   0, 0, 32'h0000_0020, 0, 0);
        // Every field at its top value.
        queue_sample(1, 1, 8'd255, 1, 1, 32'hFFFF_FFFF, 1, 1);
        wait_drained();

        // Hold and gaps at zero, widest band: any unconsumed release taps, every tap plays.
        apply_settings(8'd255, 8'd0, 16'd0, 16'd0, 16'd0);
        stride = 8;
        queue_gestures(250);
        wait_drained();

        // Inverted thresholds and the longest holds and gaps, across the wrap.
        apply_settings(8'd0, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        stride   = 40000;
        clock_ms = 32'hFFF0_0000;
        queue_gestures(250);
        wait_drained();

        // Adjacent thresholds, no hysteresis band.
        apply_settings(8'd128, 8'd127, 16'd1, 16'd1, 16'd1);
        stride = 4;
        queue_gestures(200);
        wait_drained();

        for (k = 0; k < 5; k++) begin
            p  = 8'($urandom_range(1, 255));
            r  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, p - 1));
            mh = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                             : 16'($urandom_range(0, 120));
            tg = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                             : 16'($urandom_range(0, 900));
            pg = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                             : 16'($urandom_range(0, 600));
            apply_settings(p, r, mh, tg, pg);
            stride = (int'(mh) + int'(tg)) / 4 + 8;
            queue_gestures(220);
            wait_drained();
        end

        // Back to the reset values.
        apply_settings(ttq_pkg::PRESS_LEVEL_RST, ttq_pkg::RELEASE_LEVEL_RST,
                       ttq_pkg::MIN_HOLD_MS_RST, ttq_pkg::TAP_GAP_MS_RST,
                       ttq_pkg::PLAY_GAP_MS_RST);
        stride = 120;
        queue_gestures(250);
        wait_drained();

        $display("ran %0d trigger samples under %0d register settings",
                 samples_taken, settings_used);
        $display("checked %0d verdicts: %0d play/pause taps, %0d consumed releases, %0d errors",
                 verdicts_seen, taps_emitted, consumed_seen, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
